[sv/lpht_pkg.sv]
// Package for the linear probe hash table: slot layout, codes and sizes.
// No dependencies; used by linear_probe_hash_table.sv.
package lpht_pkg;

	// Table geometry (slot count is a power of two, home slot is the low key bits)
	localparam int SLOT_AW = 10;
	localparam int SLOTS   = 1 << SLOT_AW;
	localparam int CNT_W   = SLOT_AW + 1;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	// Request modes
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		RES_DONE      = 2'd0,
		RES_NOT_FOUND = 2'd1,
		RES_FULL      = 2'd2,
		RES_UNUSED    = 2'd3
	} res_status_t;

	// Per-slot state
	typedef enum logic [1:0] {
		SLOT_EMPTY    = 2'd0,
		SLOT_OCCUPIED = 2'd1,
		SLOT_DELETED  = 2'd2,
		SLOT_UNUSED   = 2'd3
	} slot_st_t;

	// One memory word per slot
	typedef struct packed {
		slot_st_t           st;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

[sv/linear_probe_hash_table.sv]
// Linear probe hash table: an accepted request probes slots in the probe state, loads its result
// registers, then the done state loads the output register; a no-op mode goes straight to done.
// No new request is taken until the block is back in idle; a stalled result holds
// the block in its done state. One slot read per cycle sets the probe rate, up to SLOTS probes.
// After reset a clearing pass marks all SLOTS slots empty, in_stall held high.
// Depends on lpht_pkg.sv and lpht_ram.sv.
module linear_probe_hash_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [lpht_pkg::KEY_W-1:0]        key,
	input  logic signed [lpht_pkg::VAL_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic                              hit,
	output logic signed [lpht_pkg::VAL_W-1:0] value_out,
	output logic [10:0]                       key_count
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [lpht_pkg::SLOT_AW-1:0]    clr_q;
	logic [lpht_pkg::SLOT_AW-1:0]    cur_q;
	logic [lpht_pkg::SLOT_AW-1:0]    n_q;
	logic [lpht_pkg::SLOT_AW-1:0]    tomb_q;
	logic                            have_tomb_q;
	lpht_pkg::mode_t                 mode_q;
	logic [lpht_pkg::KEY_W-1:0]      key_q;
	logic [lpht_pkg::VAL_W-1:0]      value_q;
	logic [lpht_pkg::CNT_W-1:0]      count_q;
	lpht_pkg::res_status_t           res_status_q;
	logic                            res_hit_q;
	logic [lpht_pkg::VAL_W-1:0]      res_vout_q;
	logic                            out_valid_q;
	lpht_pkg::res_status_t           out_status_q;
	logic                            out_hit_q;
	logic [lpht_pkg::VAL_W-1:0]      out_vout_q;
	logic [lpht_pkg::CNT_W-1:0]      out_count_q;

	logic                            accept;
	logic                            out_free;
	logic                            ram_we;
	logic [lpht_pkg::SLOT_AW-1:0]    ram_waddr;
	logic [lpht_pkg::SLOT_W-1:0]     ram_wdata;
	logic [lpht_pkg::SLOT_AW-1:0]    ram_raddr;
	logic [lpht_pkg::SLOT_W-1:0]     ram_rdata;
	lpht_pkg::slot_t                 rd;
	lpht_pkg::slot_t                 wr;
	logic                            last;
	logic                            key_eq;
	logic                            fin;
	logic                            pr_we;
	logic [lpht_pkg::SLOT_AW-1:0]    pr_waddr;
	logic                            tomb_set;
	lpht_pkg::res_status_t           e_status;
	logic                            e_hit;
	logic [lpht_pkg::VAL_W-1:0]      e_vout;
	logic [lpht_pkg::CNT_W-1:0]      e_cnt;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign hit       = out_hit_q;
	assign value_out = $signed(out_vout_q);
	assign key_count = 11'(out_count_q);

	// Slot memory
	lpht_ram #(
		.AW (lpht_pkg::SLOT_AW),
		.DW (lpht_pkg::SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Read address: home slot on accept, else the slot after the one being checked
	always_comb begin
		if (state_q == S_IDLE) begin
			ram_raddr = key[lpht_pkg::SLOT_AW-1:0];
		end else begin
			ram_raddr = cur_q + 1'b1;
		end
	end

	// Probe evaluation on the slot read back this cycle
	always_comb begin
		rd       = lpht_pkg::slot_t'(ram_rdata);
		last     = (n_q == '1);
		key_eq   = (rd.key == key_q);
		fin      = 1'b0;
		pr_we    = 1'b0;
		pr_waddr = cur_q;
		tomb_set = 1'b0;
		wr.st    = lpht_pkg::SLOT_OCCUPIED;
		wr.key   = key_q;
		wr.value = value_q;
		e_status = lpht_pkg::RES_DONE;
		e_hit    = 1'b0;
		e_vout   = '0;
		e_cnt    = count_q;
		unique case (mode_q)
			lpht_pkg::MODE_INSERT: begin
				if (rd.st == lpht_pkg::SLOT_EMPTY) begin
					fin      = 1'b1;
					pr_we    = 1'b1;
					pr_waddr = have_tomb_q ? tomb_q : cur_q;
					e_cnt    = count_q + 1'b1;
				end else if (rd.st == lpht_pkg::SLOT_OCCUPIED && key_eq) begin
					fin   = 1'b1;
					pr_we = 1'b1;
					e_hit = 1'b1;
				end else begin
					tomb_set = (rd.st == lpht_pkg::SLOT_DELETED) && !have_tomb_q;
					if (last) begin
						fin = 1'b1;
						if (have_tomb_q || tomb_set) begin
							pr_we    = 1'b1;
							pr_waddr = have_tomb_q ? tomb_q : cur_q;
							e_cnt    = count_q + 1'b1;
						end else begin
							e_status = lpht_pkg::RES_FULL;
						end
					end
				end
			end
			lpht_pkg::MODE_LOOKUP, lpht_pkg::MODE_REMOVE: begin
				if (rd.st == lpht_pkg::SLOT_EMPTY) begin
					fin      = 1'b1;
					e_status = lpht_pkg::RES_NOT_FOUND;
				end else if (rd.st == lpht_pkg::SLOT_OCCUPIED && key_eq) begin
					fin   = 1'b1;
					e_hit = 1'b1;
					if (mode_q == lpht_pkg::MODE_LOOKUP) begin
						e_vout = rd.value;
					end else begin
						pr_we    = 1'b1;
						wr.st    = lpht_pkg::SLOT_DELETED;
						wr.key   = rd.key;
						wr.value = rd.value;
						e_cnt    = (count_q != '0) ? count_q - 1'b1 : count_q;
					end
				end else if (last) begin
					fin      = 1'b1;
					e_status = lpht_pkg::RES_NOT_FOUND;
				end
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	// Write port: clearing pass or the probe's update
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = {lpht_pkg::SLOT_EMPTY, {(lpht_pkg::KEY_W + lpht_pkg::VAL_W){1'b0}}};
		end else begin
			ram_we    = (state_q == S_PROBE) && pr_we;
			ram_waddr = pr_waddr;
			ram_wdata = wr;
		end
	end

	// Sequencer, request capture and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			cur_q        <= '0;
			n_q          <= '0;
			tomb_q       <= '0;
			have_tomb_q  <= 1'b0;
			mode_q       <= lpht_pkg::MODE_NOP;
			key_q        <= '0;
			value_q      <= '0;
			count_q      <= '0;
			res_status_q <= lpht_pkg::RES_DONE;
			res_hit_q    <= 1'b0;
			res_vout_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= lpht_pkg::RES_DONE;
			out_hit_q    <= 1'b0;
			out_vout_q   <= '0;
			out_count_q  <= '0;
		end else begin
			// output register: loaded from the done state, else drains on acceptance
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q      <= lpht_pkg::mode_t'(mode);
						key_q       <= key;
						value_q     <= $unsigned(value);
						cur_q       <= key[lpht_pkg::SLOT_AW-1:0];
						n_q         <= '0;
						have_tomb_q <= 1'b0;
						if (lpht_pkg::mode_t'(mode) == lpht_pkg::MODE_NOP) begin
							res_status_q <= lpht_pkg::RES_DONE;
							res_hit_q    <= 1'b0;
							res_vout_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (tomb_set) begin
						have_tomb_q <= 1'b1;
						tomb_q      <= cur_q;
					end
					if (fin) begin
						res_status_q <= e_status;
						res_hit_q    <= e_hit;
						res_vout_q   <= e_vout;
						count_q      <= e_cnt;
						state_q      <= S_DONE;
					end else begin
						cur_q <= cur_q + 1'b1;
						n_q   <= n_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_hit_q    <= res_hit_q;
						out_vout_q   <= res_vout_q;
						out_count_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/lpht_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Standalone generic memory; no package dependency.
module lpht_ram #(
	parameter int AW = 10,
	parameter int DW = 66
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [(1 << AW)];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
